[rtl/core/lapf_pkg.sv]
package lapf_pkg;

   // Largest row the line stores can hold.
   localparam int unsigned MAX_WIDTH = 1024;
   localparam int unsigned COL_W     = $clog2(MAX_WIDTH);

   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned WIDTH_W   = 11;
   localparam int unsigned HEIGHT_W  = 12;
   localparam int unsigned CSR_W     = 12;

   localparam int unsigned LINE_RAM_W = 2 * PIXEL_W;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
   localparam logic [PIXEL_W-1:0]  LEVEL_MAX    = '1;

   typedef enum logic [0:0] {
      REG_LINE_WIDTH   = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One pixel between the line store read and the window update.
   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [COL_W-1:0]   col;
      logic               emit;
      logic               row_end;
      logic               frame_end;
   } stage_type;

endpackage

[rtl/core/laplacian_3x3_edge_filter.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_red (8 bits, one pixel, raster order)
// rsp      out        rsp_valid/rsp_ready   rsp_level, rsp_row_end, rsp_frame_end
// csr      in         csr_wr_en, no wait    csr_index, csr_wdata (line_width, frame_height)
//
// One pixel is taken every cycle unless a stalled result holds the window stage.
// Each pixel passes the line store read (the RAM read port is registered), then the
// window update, which forms the result for interior pixel (r, c) from (r+1, c+1).
// Reset is synchronous and active high; it clears the counters, the window and the
// sizes, but not the line store, which holds garbage until two full rows have passed.
// A stalled result holds the window stage, which in turn holds off new transfers.
module laplacian_3x3_edge_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lapf_pkg::PIXEL_W-1:0]   req_red,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lapf_pkg::PIXEL_W-1:0]   rsp_level,
   output logic                           rsp_row_end,
   output logic                           rsp_frame_end,
   input  logic                           csr_wr_en,
   input  lapf_pkg::csr_index_type        csr_index,
   input  logic [lapf_pkg::CSR_W-1:0]     csr_wdata
);

   import lapf_pkg::*;

   // Configuration registers.
   logic [WIDTH_W-1:0]  line_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;

   // Sizes in use after clamping to the supported range.
   logic [WIDTH_W-1:0]  width_use;
   logic [HEIGHT_W-1:0] height_use;

   // Position of the next input pixel.
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [WIDTH_W-1:0]  col_ext, col_inc;
   logic [HEIGHT_W:0]   row_inc;

   // Window stage: the pixel whose line store entries are on the RAM output.
   logic      stage_valid_ff, stage_valid_in;
   stage_type stage_ff, stage_in;

   // Window registers: the middle row of the column two back (left neighbor) and
   // the full column one back (up, center, down).
   logic [PIXEL_W-1:0] left_ff, up_ff, center_ff, down_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] level_ff, level_in;
   logic               row_end_ff, row_end_in;
   logic               frame_end_ff, frame_end_in;

   logic req_take;
   logic stage_go;

   logic [LINE_RAM_W-1:0] ram_rd_data;
   logic [PIXEL_W-1:0]    top_rd, mid_rd;

   logic signed [WIDTH_W-1:0] sum;

   always_comb begin
      if (line_width_ff < WIDTH_MIN) begin
         width_use = WIDTH_MIN;
      end else if (line_width_ff > WIDTH_MAX) begin
         width_use = WIDTH_MAX;
      end else begin
         width_use = line_width_ff;
      end
      height_use = (frame_height_ff < HEIGHT_MIN) ? HEIGHT_MIN : frame_height_ff;
   end

   // The window stage moves on unless its result would land on a full output
   // register that is not being drained this cycle.
   assign stage_go  = stage_valid_ff && (!stage_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || stage_go;
   assign req_take  = req_valid && req_ready;

   // Position bookkeeping and the crop decision happen at the input transfer.
   always_comb begin
      col_ext = {1'b0, col_ff};
      col_inc = col_ext + WIDTH_W'(1);
      row_inc = {1'b0, row_ff} + (HEIGHT_W+1)'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (req_take) begin
         if (col_inc >= width_use) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, height_use}) ? '0 : row_inc[HEIGHT_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end

      stage_in           = stage_ff;
      stage_in.red       = req_red;
      stage_in.col       = col_ff;
      stage_in.emit      = (col_ext >= WIDTH_W'(2)) && (col_ext < width_use) &&
                           (row_ff >= HEIGHT_W'(2)) && (row_ff < height_use);
      stage_in.row_end   = (col_inc == width_use);
      stage_in.frame_end = (col_inc == width_use) && (row_inc == {1'b0, height_use});

      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   // Both line stores share one RAM: the upper row in the high byte, the middle
   // row in the low byte. The read is issued at the input transfer and the write
   // back comes when that pixel leaves the window stage. Consecutive pixels always
   // sit in different columns, so a read never meets a write to the same entry.
   lapf_ram #(
      .WIDTH (LINE_RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (stage_go),
      .wr_addr (stage_ff.col),
      .wr_data ({mid_rd, stage_ff.red}),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign top_rd = ram_rd_data[LINE_RAM_W-1:PIXEL_W];
   assign mid_rd = ram_rd_data[PIXEL_W-1:0];

   // Four times the center less the four neighbors; the right neighbor is the
   // middle row entry just read for the current column.
   always_comb begin
      sum = $signed({1'b0, center_ff, 2'b00})
          - $signed(WIDTH_W'(up_ff))
          - $signed(WIDTH_W'(down_ff))
          - $signed(WIDTH_W'(left_ff))
          - $signed(WIDTH_W'(mid_rd));

      if (sum < 0) begin
         level_in = '0;
      end else if (sum > $signed(WIDTH_W'(LEVEL_MAX))) begin
         level_in = LEVEL_MAX;
      end else begin
         level_in = sum[PIXEL_W-1:0];
      end
      row_end_in   = stage_ff.row_end;
      frame_end_in = stage_ff.frame_end;

      if (stage_go && stage_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         left_ff         <= '0;
         up_ff           <= '0;
         center_ff       <= '0;
         down_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_LINE_WIDTH:   line_width_ff   <= csr_wdata[WIDTH_W-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (stage_go) begin
            left_ff   <= center_ff;
            up_ff     <= top_rd;
            center_ff <= mid_rd;
            down_ff   <= stage_ff.red;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
      if (stage_go && stage_ff.emit) begin
         level_ff     <= level_in;
         row_end_ff   <= row_end_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = level_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

[rtl/core/lapf_ram.sv]
module lapf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/laplacian_3x3_edge_filter_test.sv]
`timescale 1ns / 1ps

module laplacian_3x3_edge_filter_test;
   import lapf_pkg::*;

   // Pixels that do not end up in the random part are not counted toward it.
   localparam int unsigned RANDOM_ITEMS   = 700;
   // The last stretch of the random part runs with both sides at full rate.
   localparam int unsigned STEADY_ITEMS   = 300;
   // A pixel needs a line store read and a window update, so the settle time
   // below is plenty for the pipeline to empty after the last result.
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned LONG_HOLD      = 400;
   // Cycles without any transfer before the run is declared hung. The longest
   // quiet stretch of a correct run is the long hold plus one idle burst.
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [PIXEL_W-1:0] level;
      logic               row_end;
      logic               frame_end;
   } level_result_type;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_red       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [PIXEL_W-1:0]   rsp_level;
   logic                 rsp_row_end;
   logic                 rsp_frame_end;
   logic                 csr_wr_en     = 1'b0;
   csr_index_type        csr_index     = REG_LINE_WIDTH;
   logic [CSR_W-1:0]     csr_wdata     = '0;

   laplacian_3x3_edge_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level     (rsp_level),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Our own copy of the filter state. The line stores start unknown, just as
   // in the hardware; the known flags follow which entries hold real pixels so
   // that a width change in the middle of a frame is only made when every
   // column it will read has been filled.
   logic [WIDTH_W-1:0]   model_line_width   = WIDTH_RESET;
   logic [HEIGHT_W-1:0]  model_frame_height = HEIGHT_RESET;
   logic [PIXEL_W-1:0]   upper_line   [MAX_WIDTH];
   logic [PIXEL_W-1:0]   middle_line  [MAX_WIDTH];
   bit                   upper_known  [MAX_WIDTH];
   bit                   middle_known [MAX_WIDTH];
   // Taps 0..2 hold the column two back (top, middle, bottom), taps 3..5 the
   // column one back.
   logic [PIXEL_W-1:0]   window_taps  [6] = '{default: '0};
   int unsigned          column_now = 0;
   int unsigned          row_now    = 0;

   level_result_type     expected_levels [$];
   logic [PIXEL_W-1:0]   pixel_backlog [$];
   int unsigned          mismatch_count = 0;

   // Idle controls shared between the stimulus and the two handshake processes.
   int unsigned          req_idle_percent = 0;
   int unsigned          rsp_idle_percent = 0;
   int unsigned          holds_asked      = 0;

   function automatic int unsigned effective_width(input logic [WIDTH_W-1:0] value);
      if (value < 3) return 3;
      if (value > MAX_WIDTH) return MAX_WIDTH;
      return value;
   endfunction

   function automatic int unsigned effective_height(input logic [HEIGHT_W-1:0] value);
      return (value < 3) ? 3 : value;
   endfunction

   // Works out the result, if any, that one accepted pixel produces, and moves
   // the window, the line stores and the raster counters on by one pixel.
   function automatic void predict_laplacian(input logic [PIXEL_W-1:0] pixel);
      int unsigned        w;
      int unsigned        h;
      int unsigned        col;
      int unsigned        row;
      logic [PIXEL_W-1:0] above;
      logic [PIXEL_W-1:0] beside;
      int                 sum;
      level_result_type   result;
      w = effective_width(model_line_width);
      h = effective_height(model_frame_height);
      col = column_now;
      row = row_now;
      above = '0;
      beside = '0;
      if (col < MAX_WIDTH) begin
         above = upper_line[col];
         beside = middle_line[col];
      end

      // The centre is one column back in the middle row; the right neighbor is
      // the middle store entry being read right now.
      if (col >= 2 && col < w && row >= 2 && row < h) begin
         sum = 4 * int'(window_taps[4]) - int'(window_taps[3]) - int'(window_taps[5])
               - int'(window_taps[1]) - int'(beside);
         if (sum < 0) sum = 0;
         if (sum > int'(LEVEL_MAX)) sum = int'(LEVEL_MAX);
         result.level = sum[PIXEL_W-1:0];
         result.row_end = (col == w - 1);
         result.frame_end = (col == w - 1) && (row == h - 1);
         expected_levels.push_back(result);
      end

      window_taps[0] = window_taps[3];
      window_taps[1] = window_taps[4];
      window_taps[2] = window_taps[5];
      window_taps[3] = above;
      window_taps[4] = beside;
      window_taps[5] = pixel;

      if (col < MAX_WIDTH) begin
         upper_line[col] = beside;
         upper_known[col] = middle_known[col];
         middle_line[col] = pixel;
         middle_known[col] = 1'b1;
      end

      // A counter already beyond a freshly shrunk size simply wraps here.
      if (col + 1 >= w) begin
         column_now = 0;
         row_now = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         column_now = col + 1;
      end
   endfunction

   // A new width is harmless at the start of a frame, since the first two rows
   // refill the stores before anything is read. In the middle of a frame every
   // column that the new width uses must already hold real pixels in both stores.
   function automatic bit width_change_safe(input int unsigned new_width);
      if (column_now == 0 && row_now == 0) return 1'b1;
      if (new_width == effective_width(model_line_width)) return 1'b1;
      for (int unsigned c = 0; c < new_width; c++) begin
         if (!upper_known[c] || !middle_known[c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int unsigned pixels_to_frame_start();
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      int unsigned count;
      w = effective_width(model_line_width);
      h = effective_height(model_frame_height);
      col = column_now;
      row = row_now;
      count = 0;
      while (col != 0 || row != 0) begin
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col++;
         end
         count++;
      end
      return count;
   endfunction

   // Black and white pixels are favored so that the clamp at both ends is
   // reached often.
   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned idle_choice();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 40;
      endcase
   endfunction

   // Sender. A pixel that has been offered stays on the bus until its transfer;
   // only then may a random gap start or the next pixel follow.
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_idle_percent != 0 && $urandom_range(0, 99) < req_idle_percent) begin
            gap_left <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_red <= pixel_backlog.pop_front();
         end
      end
   end

   // Receiver. Besides the short random stalls it can hold off for a long
   // stretch once a result is waiting, so that the window stage fills and the
   // block has to refuse pixels.
   int unsigned stall_left   = 0;
   int unsigned holds_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked && rsp_valid) begin
         holds_served <= holds_served + 1;
         stall_left <= LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_percent != 0 && $urandom_range(0, 99) < rsp_idle_percent) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Every pixel transfer goes through the filter model; every result
   // transfer is compared with the oldest level still expected.
   always @(posedge clock) begin : watch_transfers
      level_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_laplacian(req_red);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected result: level %0d row_end %0b frame_end %0b",
                           $realtime, rsp_level, rsp_row_end, rsp_frame_end);
               end
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level !== want.level || rsp_row_end !== want.row_end ||
                   rsp_frame_end !== want.frame_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"%0t: result mismatch: expected level %0d row_end %0b ",
                               "frame_end %0b, got level %0d row_end %0b frame_end %0b"},
                              $realtime, want.level, want.row_end, want.frame_end,
                              rsp_level, rsp_row_end, rsp_frame_end);
                  end
               end
            end
         end
      end
   end

   // Watchdog on transfers of either channel.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Both registers are written back to back; the model copy changes at the
   // edge where the block takes each write. Only called while the block is idle.
   task automatic set_sizes(input logic [CSR_W-1:0] width_value,
                            input logic [CSR_W-1:0] height_value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_LINE_WIDTH;
      csr_wdata <= width_value;
      @(posedge clock);
      model_line_width = width_value[WIDTH_W-1:0];
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= height_value;
      @(posedge clock);
      model_frame_height = height_value[HEIGHT_W-1:0];
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued pixel has made its transfer and every expected
   // level has arrived, then lets the pipeline run empty. A pixel that makes
   // no result may still be on its way into the line store at that point.
   task automatic drain_results();
      while (pixel_backlog.size() != 0 || req_valid || expected_levels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_pixels(input int unsigned count);
      repeat (count) pixel_backlog.push_back(random_pixel());
      drain_results();
   endtask

   initial begin : stimulus
      logic [CSR_W-1:0] width_value;
      logic [CSR_W-1:0] height_value;
      int unsigned      burst;
      int unsigned      random_items;
      int unsigned      phase_count;
      random_items = 0;
      phase_count = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_percent = 20;
      rsp_idle_percent = 20;

      // Smallest frame, reached through values below the minimum (the width
      // write also carries a bit beyond the register). A bright centre on a
      // black field saturates high; a dark centre on white saturates at zero.
      // Each frame has one result, which ends both its row and the frame.
      set_sizes({1'b1, 11'd2}, 12'd0);
      for (int i = 0; i < 9; i++) pixel_backlog.push_back((i == 4) ? 8'd255 : 8'd0);
      for (int i = 0; i < 9; i++) pixel_backlog.push_back((i == 4) ? 8'd0 : 8'd255);
      drain_results();

      // Width shrink in the middle of a row: the column counter is already
      // beyond the new width, so the next pixel gives nothing and wraps.
      set_sizes(12'd20, 12'd10);
      run_pixels(3 * 20 + 15);
      set_sizes(12'd8, 12'd10);
      run_pixels(pixels_to_frame_start() + 8 * 10);

      // Tallest frame, then a height shrink while the row counter is past it.
      set_sizes(12'd5, 12'd4095);
      run_pixels(100);
      set_sizes(12'd5, 12'd6);
      run_pixels(pixels_to_frame_start() + 5 * 6);

      // One whole mid-sized frame with the long receiver hold: the first result
      // is held back while pixels keep coming, so the block refuses the input.
      holds_asked++;
      set_sizes(12'd16, 12'd8);
      run_pixels(16 * 8);

      // Random part: small frames with random sizes, whole frames mostly, a
      // partial frame now and then so that the next change hits mid-frame.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items + STEADY_ITEMS >= RANDOM_ITEMS) begin
            req_idle_percent = 0;
            rsp_idle_percent = 0;
         end else begin
            req_idle_percent = idle_choice();
            rsp_idle_percent = idle_choice();
         end
         width_value = CSR_W'($urandom_range(3, 16));
         height_value = CSR_W'($urandom_range(3, 8));
         case ($urandom_range(0, 9))
            0: width_value = CSR_W'($urandom_range(0, 2));
            1: width_value = {1'b1, 11'($urandom_range(3, 16))};
            2: width_value = CSR_W'(model_line_width);
            3: height_value = CSR_W'($urandom_range(0, 2));
            default: ;
         endcase
         // A width the stores cannot yet serve waits for the frame to end.
         if (!width_change_safe(effective_width(width_value[WIDTH_W-1:0]))) begin
            burst = pixels_to_frame_start();
            random_items += burst;
            run_pixels(burst);
         end
         // The steady stretch at the end stays free of any receiver hold.
         if (phase_count == 3 && rsp_idle_percent != 0) holds_asked++;
         set_sizes(width_value, height_value);
         burst = effective_width(model_line_width) * effective_height(model_frame_height)
                 * $urandom_range(1, 2);
         if ($urandom_range(0, 2) == 0) burst += $urandom_range(1, burst / 2);
         random_items += burst;
         phase_count++;
         run_pixels(burst);
      end

      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lapf_pkg.sv
rtl/core/lapf_ram.sv
rtl/core/laplacian_3x3_edge_filter.sv
verif/laplacian_3x3_edge_filter_test.sv
